// ===== src/assert_macros.svh =====
// Shared assertion macros; each expands to one labeled concurrent assertion
// clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/scpr_pkg.sv =====
package scpr_pkg;

    localparam int MAX_LINE    = 512;
    localparam int LEN_W       = $clog2(MAX_LINE);
    localparam int HEAD_DEPTH  = 17;
    localparam int FIELD_START = 10;
    localparam int FIELD_CHARS = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  CH_NUL   = 8'h00;
    localparam logic [7:0]  CH_LF    = 8'h0A;
    localparam logic [7:0]  CH_CR    = 8'h0D;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CH_LA    = 8'h61;
    localparam logic [7:0]  CH_LF_HX = 8'h66;
    localparam logic [7:0]  CH_UA    = 8'h41;
    localparam logic [7:0]  CH_UF    = 8'h46;
    localparam logic [63:0] CMD_WORD = "color000";

    typedef logic [7:0] char_t;

    // One finished line, as handed from the front to the back.
    typedef struct packed {
        logic                         ok;
        logic [FIELD_CHARS-1:0][7:0]  field_chars;  // index 0 is slot FIELD_START
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic is_digit(input char_t c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Returns {valid, nibble}.
    function automatic logic [4:0] hex_val(input char_t c);
        logic [7:0] d;
        begin
            hex_val = 5'd0;
            if ((c >= CH_ZERO) && (c <= CH_NINE))
            begin
                d = c - CH_ZERO;
                hex_val = {1'b1, d[3:0]};
            end
            else if ((c >= CH_LA) && (c <= CH_LF_HX))
            begin
                d = c - CH_LA + 8'd10;
                hex_val = {1'b1, d[3:0]};
            end
            else if ((c >= CH_UA) && (c <= CH_UF))
            begin
                d = c - CH_UA + 8'd10;
                hex_val = {1'b1, d[3:0]};
            end
        end
    endfunction

    // Two-character level; stops at the first non-hex character.
    function automatic logic [7:0] hex_pair(input char_t c0, input char_t c1);
        logic [4:0] v0;
        logic [4:0] v1;
        begin
            v0 = hex_val(c0);
            v1 = hex_val(c1);
            if (!v0[4])
                hex_pair = 8'd0;
            else if (!v1[4])
                hex_pair = {4'd0, v0[3:0]};
            else
                hex_pair = {v0[3:0], v1[3:0]};
        end
    endfunction

endpackage

// ===== src/scpr_queue.sv =====
`include "assert_macros.svh"

module scpr_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scpr_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output scpr_pkg::cmd_t  head_cmd,
    output scpr_pkg::q_stat_t stat
);
    import scpr_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
            ptr_inc = '0;
        else
            ptr_inc = p + 1'b1;
    endfunction

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    `ASSERT_ALWAYS(a_q_count_cap, count_reg <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
    `ASSERT_SAME(a_q_no_overrun, push, !stat.full, "push into full queue")

endmodule

// ===== src/scpr_front.sv =====
`include "assert_macros.svh"

module scpr_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        rx_byte,
    input  scpr_pkg::q_stat_t q_stat,
    output logic              push,
    output scpr_pkg::cmd_t    push_cmd
);
    import scpr_pkg::*;

    char_t            head_reg [HEAD_DEPTH];
    char_t            head_next [HEAD_DEPTH];
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] len_plus;
    logic             accept;
    logic             is_cr, is_skip, can_store;
    logic             word_ok, count_ok;

    assign in_stall  = q_stat.full;
    assign accept    = in_valid && !in_stall;
    assign is_cr     = (rx_byte == CH_CR);
    assign is_skip   = (rx_byte == CH_NUL) || (rx_byte == CH_LF);
    assign can_store = (len_reg < LEN_W'(MAX_LINE - 1));
    assign len_plus  = len_reg + 1'b1;

    // Classify the line held in the head slots.
    always_comb
    begin
        word_ok = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if (head_reg[i] != CMD_WORD[63 - 8 * i -: 8])
                word_ok = 1'b0;
        end
        count_ok = is_digit(head_reg[8])
            && ((head_reg[8] != CH_ZERO)
                || (is_digit(head_reg[9]) && (head_reg[9] != CH_ZERO)));
        push_cmd.ok = word_ok && count_ok;
        for (int k = 0; k < FIELD_CHARS; k++)
            push_cmd.field_chars[k] = head_reg[FIELD_START + k];
    end

    assign push = accept && is_cr && (len_reg != '0);

    always_comb
    begin
        len_next = len_reg;
        for (int i = 0; i < HEAD_DEPTH; i++)
            head_next[i] = head_reg[i];
        if (accept && !is_skip)
        begin
            if (is_cr)
                len_next = '0;
            else if (can_store)
            begin
                // Write the character and zero the slot after it.
                for (int i = 0; i < HEAD_DEPTH; i++)
                begin
                    if (len_reg == LEN_W'(i))
                        head_next[i] = rx_byte;
                    else if (len_plus == LEN_W'(i))
                        head_next[i] = CH_NUL;
                end
                len_next = len_plus;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            for (int i = 0; i < HEAD_DEPTH; i++)
                head_reg[i] <= CH_NUL;
        end
        else
        begin
            len_reg <= len_next;
            for (int i = 0; i < HEAD_DEPTH; i++)
                head_reg[i] <= head_next[i];
        end
    end

    `ASSERT_ALWAYS(a_len_cap, len_reg <= LEN_W'(MAX_LINE - 1), "line length past cap")

endmodule

// ===== src/scpr_back.sv =====
`include "assert_macros.svh"

module scpr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  scpr_pkg::cmd_t    cmd,
    input  scpr_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              status,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue
);
    import scpr_pkg::*;

    logic [23:0] held_color_reg, held_color_next;
    logic        valid_reg, valid_next;
    logic        status_reg;
    logic [23:0] color_out_reg;
    logic [23:0] decoded;

    assign decoded = {hex_pair(cmd.field_chars[0], cmd.field_chars[1]),
                      hex_pair(cmd.field_chars[2], cmd.field_chars[3]),
                      hex_pair(cmd.field_chars[4], cmd.field_chars[5])};

    // Advance when the output register is free or being taken.
    assign pop = !q_stat.empty && (!valid_reg || !out_stall);

    always_comb
    begin
        held_color_next = held_color_reg;
        if (pop && cmd.ok)
            held_color_next = decoded;
        valid_next = valid_reg;
        if (pop)
            valid_next = 1'b1;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_color_reg <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            held_color_reg <= held_color_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg    <= !cmd.ok;
            color_out_reg <= held_color_next;
        end
    end

    assign out_valid = valid_reg;
    assign status    = status_reg;
    assign red       = color_out_reg[23:16];
    assign green     = color_out_reg[15:8];
    assign blue      = color_out_reg[7:0];

    `ASSERT_NEXT(a_held_keep, !(pop && cmd.ok), held_color_reg == $past(held_color_reg), "held color changed without color command")
    `ASSERT_SAME(a_pop_nonempty, pop, !q_stat.empty, "pop from empty queue")

endmodule

// ===== src/serial_color_command_parser_top.sv =====
// Serial color command parser. Takes one received byte per cycle on rx_byte
// (in_valid/in_stall); NUL and LF are dropped, CR closes the line, and every
// non-empty line yields one transaction on status/red/green/blue
// (out_valid/out_stall): status 0 when the line starts with "color000", a
// nonzero 1-2 digit count, and slots 10 to 15 then load the held color as hex
// RGB; status 1 otherwise with the held color unchanged. Throughput is one
// byte per cycle while in_stall is low. Each line's command passes through
// a two-entry command queue between the line front end and the decode stage
// into its output register; in_stall rises only when that queue is full,
// i.e. when results back up behind out_stall. No clearing pass after reset.
module serial_color_command_parser_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       status,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);
    import scpr_pkg::*;

    cmd_t    push_cmd;
    cmd_t    head_cmd;
    q_stat_t q_stat;
    logic    push;
    logic    pop;

    scpr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_stat   (q_stat),
        .push     (push),
        .push_cmd (push_cmd)
    );

    scpr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    scpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

endmodule

// ===== dv/serial_color_command_parser_top_tb.sv =====
module serial_color_command_parser_top_tb;

    import scpr_pkg::*;

    localparam int RANDOM_BYTES = 150;
    localparam int QUIET_TAIL   = 40;
    localparam int IDLE_LIMIT   = 1000;
    localparam int SETTLE       = 10;

    typedef struct packed {
        logic       status;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_report_t;

    // Tracks the line store and held color, and queues the report each CR causes.
    class color_line_tracker;
        int unsigned   line_len;
        logic [7:0]    head [HEAD_DEPTH];
        logic [23:0]   held;
        color_report_t pending [$];
        int unsigned   errors;

        function new();
            line_len = 0;
            foreach (head[i])
                head[i] = 8'd0;
            held   = 24'd0;
            errors = 0;
        endfunction

        function int hex_nibble(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return c - "0";
            if (c >= "a" && c <= "f")
                return c - "a" + 10;
            if (c >= "A" && c <= "F")
                return c - "A" + 10;
            return -1;
        endfunction

        // Stop at the first non-hex character.
        function logic [7:0] hex_level(int pos);
            int lvl;
            int d;
            lvl = 0;
            for (int k = 0; k < 2; k++)
            begin
                d = hex_nibble(head[pos + k]);
                if (d < 0)
                    break;
                lvl = lvl * 16 + d;
            end
            return lvl[7:0];
        endfunction

        function void note_byte(logic [7:0] c);
            bit            match;
            int            count;
            color_report_t rep;
            if (c == CH_NUL || c == CH_LF)
                return;
            if (c != CH_CR)
            begin
                // Drop characters past the cap.
                if (line_len < MAX_LINE - 1)
                begin
                    if (line_len < HEAD_DEPTH)
                        head[line_len] = c;
                    if (line_len + 1 < HEAD_DEPTH)
                        head[line_len + 1] = 8'd0;
                    line_len++;
                end
                return;
            end
            if (line_len == 0)
                return;
            line_len = 0;
            match = 1'b1;
            for (int i = 0; i < 8; i++)
                if (head[i] != CMD_WORD[63 - 8 * i -: 8])
                    match = 1'b0;
            count = 0;
            for (int i = 8; i < 10; i++)
            begin
                if (head[i] < "0" || head[i] > "9")
                    break;
                count = count * 10 + (head[i] - "0");
            end
            if (match && count >= 1)
            begin
                held = {hex_level(FIELD_START), hex_level(FIELD_START + 2),
                        hex_level(FIELD_START + 4)};
                rep.status = 1'b0;
            end
            else
                rep.status = 1'b1;
            rep.red   = held[23:16];
            rep.green = held[15:8];
            rep.blue  = held[7:0];
            pending.push_back(rep);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_report(logic st, logic [7:0] r, logic [7:0] g, logic [7:0] b);
            color_report_t want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d color %02h%02h%02h",
                         $time, st, r, g, b);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("status", want.status, st);
            compare_field("red", want.red, r);
            compare_field("green", want.green, g);
            compare_field("blue", want.blue, b);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_stall;
    logic       status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    color_line_tracker tracker = new();

    int unsigned idle_cycles;
    int unsigned bytes_sent;
    int unsigned random_start;
    int unsigned stall_left;
    bit          quiet;
    bit          paused;

    serial_color_command_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.note_byte(rx_byte);
            if (out_valid && !out_stall)
                tracker.check_report(status, red, green, blue);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // Receiver backpressure in bursts; none once the run goes quiet.
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (quiet)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Starts and ends at a falling edge.
    task automatic send_byte(logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
        end
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Hold the sender until every queued report has come out.
    task automatic drain_reports();
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [7:0] rand_hex_char();
        case ($urandom_range(0, 2))
            0:       return 8'("0") + 8'($urandom_range(0, 9));
            1:       return 8'("a") + 8'($urandom_range(0, 5));
            default: return 8'("A") + 8'($urandom_range(0, 5));
        endcase
    endfunction

    task automatic send_random_line();
        logic [7:0]  line_q [$];
        int unsigned kind;
        int unsigned sel;
        kind = $urandom_range(0, 19);
        if (kind <= 14)
        begin
            for (int i = 0; i < 8; i++)
                line_q.push_back(CMD_WORD[63 - 8 * i -: 8]);
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                line_q.push_back("0");
                line_q.push_back("0");
            end
            else if (sel == 1)
            begin
                line_q.push_back(8'("0") + 8'($urandom_range(0, 9)));
                line_q.push_back("x");
            end
            else if (sel == 2)
                line_q.push_back(8'($urandom_range(0, 255)));
            else
            begin
                line_q.push_back(8'("0") + 8'($urandom_range(0, 9)));
                line_q.push_back(8'("0") + 8'($urandom_range(1, 9)));
            end
            repeat ($urandom_range(0, 6))
                line_q.push_back(rand_hex_char());
            if ($urandom_range(0, 3) == 0)
                line_q[$urandom_range(8, line_q.size() - 1)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 4))
                    line_q.push_back(8'($urandom_range(32, 126)));
            // Break the command word.
            if (kind >= 12)
                line_q[$urandom_range(0, 7)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 4) == 0)
                line_q.insert($urandom_range(0, line_q.size()),
                              ($urandom_range(0, 1) == 0) ? CH_NUL : CH_LF);
        end
        else if (kind <= 17)
        begin
            repeat ($urandom_range(1, 20))
                line_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 18)
            line_q.push_back(CH_LF);
        foreach (line_q[i])
            send_byte(line_q[i]);
        send_byte(CH_CR);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        rx_byte    = 8'd0;
        quiet      = 1'b0;
        paused     = 1'b0;
        bytes_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty line, ignored bytes, then plain commands.
        send_byte(CH_CR);
        send_byte(CH_NUL);
        send_byte(CH_LF);
        send_byte(CH_CR);
        send_text("color00001ff8000");
        send_byte(CH_CR);
        send_text("color00099ABCDEF");
        send_byte(CH_CR);
        send_text("color00001aBcDeF");
        send_byte(CH_CR);
        // Zero count, missing count and a miscased command word leave the color alone.
        send_text("color00000123456");
        send_byte(CH_CR);
        send_text("color000xx123456");
        send_byte(CH_CR);
        send_text("Color00001ffffff");
        send_byte(CH_CR);
        // Single count digit; the hex field sits past the end of the line.
        send_text("color0001a");
        send_byte(CH_CR);
        // Short line picks up stale slots left by the longer one.
        send_text("color00012345678");
        send_byte(CH_CR);
        send_text("color00012a");
        send_byte(CH_CR);
        send_text("color00012");
        send_byte(CH_CR);
        // Hex decode stops early.
        send_text("color00001fg1234");
        send_byte(CH_CR);
        send_text("color00001g01234");
        send_byte(CH_CR);
        // NUL and LF inside a command are skipped.
        send_text("colo");
        send_byte(CH_NUL);
        send_text("r000");
        send_byte(CH_LF);
        send_text("01aabbcc");
        send_byte(CH_CR);
        send_byte(8'hFF);
        send_byte(CH_CR);
        // Overlong line: characters past the cap are dropped.
        send_text("color00001112233");
        repeat (MAX_LINE - 8)
            send_byte(($urandom_range(0, 1) == 0) ? 8'h7A : 8'hFF);
        send_byte(CH_CR);
        send_text("color00001010203");
        send_byte(CH_CR);
        drain_reports();

        random_start = bytes_sent;
        while (bytes_sent < random_start + RANDOM_BYTES)
        begin
            if (!paused && bytes_sent >= random_start + RANDOM_BYTES / 2)
            begin
                drain_reports();
                paused = 1'b1;
            end
            if (bytes_sent >= random_start + RANDOM_BYTES - QUIET_TAIL)
                quiet = 1'b1;
            send_random_line();
        end
        in_valid <= 1'b0;

        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (tracker.errors == 0 && tracker.pending.size() == 0)
            $display("TEST PASSED");
        else
        begin
            if (tracker.pending.size() != 0)
                $display("%0t: %0d expected results never arrived",
                         $time, tracker.pending.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
